// ===== hw/rtl/sample_frame_command_ctl_top_defines.svh =====
// assertion macros used by the frame command controller rtl
// no dependencies; included by modules that carry assertions
`ifndef SAMPLE_FRAME_COMMAND_CTL_TOP_DEFINES_SVH
`define SAMPLE_FRAME_COMMAND_CTL_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SFC_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sfc assertion failed");

// next-cycle implication, checked outside reset
`define SFC_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sfc assertion failed");

`endif

// ===== hw/rtl/sfc_pkg.sv =====
// types, codes and constants for the sample frame command controller
// no dependencies; imported by every module of the block
package sfc_pkg;

    localparam int CHANNELS  = 4;
    localparam int FRAME_LEN = 2 * CHANNELS + 2;
    localparam int IDX_W     = $clog2(FRAME_LEN);
    localparam int CNT_W     = $clog2(FRAME_LEN + 1);
    localparam int SAMPLE_W  = 12;
    localparam int CFG_W     = 12;

    // run modes
    localparam logic [1:0] MODE_STOP = 2'd0;
    localparam logic [1:0] MODE_LIVE = 2'd1;
    localparam logic [1:0] MODE_TEST = 2'd2;

    // command bytes and replies
    localparam logic [7:0] CMD_LIVE  = 8'ha5;
    localparam logic [7:0] CMD_STOP  = 8'ha6;
    localparam logic [7:0] CMD_TEST  = 8'ha7;
    localparam logic [7:0] ACK_LIVE  = 8'hfd;
    localparam logic [7:0] ACK_STOP  = 8'hfe;
    localparam logic [7:0] ACK_TEST  = 8'hf1;
    localparam logic [7:0] FRAME_SOF = 8'hfa;
    localparam logic [7:0] FRAME_EOF = 8'hfb;

    // register indexes
    localparam logic [1:0] REG_LIVE_PERIOD = 2'd0;
    localparam logic [1:0] REG_TEST_PERIOD = 2'd1;
    localparam logic [1:0] REG_BUZZ_LEN    = 2'd2;
    localparam logic [1:0] REG_RAMP_LIMIT  = 2'd3;

    typedef struct packed {
        logic [9:0]          live_period;
        logic [9:0]          test_period;
        logic [7:0]          buzz_len;
        logic [SAMPLE_W-1:0] ramp_limit;
    } t_cfg;

    typedef struct packed {
        logic                 command;
        logic                 rx_port;
        logic [7:0]           rx_byte;
        logic [SAMPLE_W-1:0]  sample_a;
        logic [SAMPLE_W-1:0]  sample_b;
        logic [SAMPLE_W-1:0]  sample_c;
        logic [SAMPLE_W-1:0]  sample_d;
    } t_item;

    // one step's worth of results, handed from core to emitter
    typedef struct packed {
        logic [FRAME_LEN-1:0][7:0] bytes;
        logic [CNT_W-1:0]          cnt;
        logic                      byte_valid;
        logic                      to_port_one;
        logic                      to_port_two;
        logic                      lamp_one;
        logic                      lamp_three;
        logic                      buzzer;
        logic [1:0]                mode;
    } t_frame;

endpackage

// ===== hw/rtl/sfc_core.sv =====
// step logic: mode, lamps, buzzer and ramps, and frame assembly
// depends on sfc_pkg
module sfc_core import sfc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  t_item  i_item,
    input  t_cfg   i_cfg,
    output t_frame o_frame
);

    logic [1:0]          r_mode, n_mode;
    logic [9:0]          r_lamp_cnt, n_lamp_cnt;
    logic                r_lamp1, n_lamp1;
    logic                r_lamp3, n_lamp3;
    logic [7:0]          r_buzz_cnt, n_buzz_cnt;
    logic                r_buzz, n_buzz;
    logic [SAMPLE_W-1:0] r_ramp [CHANNELS];
    logic [SAMPLE_W-1:0] n_ramp [CHANNELS];

    logic [SAMPLE_W-1:0] val [CHANNELS];
    logic [SAMPLE_W:0]   ramp_sum [CHANNELS];
    logic [10:0]         lamp_next;
    logic [9:0]          period;
    logic [8:0]          buzz_next;

    always_comb begin
        n_mode     = r_mode;
        n_lamp_cnt = r_lamp_cnt;
        n_lamp1    = r_lamp1;
        n_lamp3    = r_lamp3;
        n_buzz_cnt = r_buzz_cnt;
        n_buzz     = r_buzz;
        n_ramp     = r_ramp;
        o_frame    = '0;
        o_frame.cnt = CNT_W'(1);
        period     = (r_mode == MODE_LIVE) ? i_cfg.live_period : i_cfg.test_period;
        lamp_next  = {1'b0, r_lamp_cnt} + 11'd1;
        buzz_next  = {1'b0, r_buzz_cnt} + 9'd1;

        for (int i = 0; i < CHANNELS; i++) begin
            ramp_sum[i] = {1'b0, r_ramp[i]} + (SAMPLE_W+1)'(2 * (i + 1));
            case (i)
                0:       val[i] = i_item.sample_a;
                1:       val[i] = i_item.sample_b;
                2:       val[i] = i_item.sample_c;
                3:       val[i] = i_item.sample_d;
                default: val[i] = '0;
            endcase
            if (r_mode == MODE_TEST) begin
                val[i] = (ramp_sum[i] > {1'b0, i_cfg.ramp_limit}) ? '0
                                                                   : ramp_sum[i][SAMPLE_W-1:0];
            end
        end

        if (!i_item.command) begin
            if (r_mode == MODE_LIVE || r_mode == MODE_TEST) begin
                o_frame.bytes[0] = FRAME_SOF;
                for (int i = 0; i < CHANNELS; i++) begin
                    o_frame.bytes[2*i+1] = {3'b000, val[i][11:7]};
                    o_frame.bytes[2*i+2] = {1'b0, val[i][6:0]};
                    if (r_mode == MODE_TEST) begin
                        n_ramp[i] = val[i];
                    end
                end
                o_frame.bytes[FRAME_LEN-1] = FRAME_EOF;
                o_frame.cnt         = CNT_W'(FRAME_LEN);
                o_frame.byte_valid  = 1'b1;
                o_frame.to_port_one = 1'b1;
                o_frame.to_port_two = 1'b1;
                if (lamp_next > {1'b0, period}) begin
                    n_lamp1    = ~r_lamp1;
                    n_lamp_cnt = '0;
                end else begin
                    n_lamp_cnt = lamp_next[9:0];
                end
            end else begin
                n_lamp1 = 1'b0;
            end
            if (r_buzz_cnt != 8'd0) begin
                n_buzz     = 1'b1;
                n_buzz_cnt = (buzz_next > {1'b0, i_cfg.buzz_len}) ? 8'd0 : buzz_next[7:0];
            end else begin
                n_buzz = 1'b0;
            end
        end else begin
            unique case (i_item.rx_byte)
                CMD_LIVE: begin
                    n_mode              = MODE_LIVE;
                    n_buzz_cnt          = 8'd1;
                    o_frame.bytes[0]    = ACK_LIVE;
                    o_frame.byte_valid  = 1'b1;
                    o_frame.to_port_one = ~i_item.rx_port;
                    o_frame.to_port_two = i_item.rx_port;
                end
                CMD_STOP: begin
                    n_mode              = MODE_STOP;
                    n_buzz_cnt          = 8'd1;
                    o_frame.bytes[0]    = ACK_STOP;
                    o_frame.byte_valid  = 1'b1;
                    o_frame.to_port_one = ~i_item.rx_port;
                    o_frame.to_port_two = i_item.rx_port;
                end
                CMD_TEST: begin
                    n_mode              = MODE_TEST;
                    n_buzz_cnt          = 8'd1;
                    o_frame.bytes[0]    = ACK_TEST;
                    o_frame.byte_valid  = 1'b1;
                    o_frame.to_port_one = 1'b1;
                end
                default: begin
                end
            endcase
            if (i_item.rx_port) begin
                n_lamp3 = ~r_lamp3;
            end
        end

        o_frame.lamp_one   = n_lamp1;
        o_frame.lamp_three = n_lamp3;
        o_frame.buzzer     = n_buzz;
        o_frame.mode       = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_STOP;
            r_lamp_cnt <= '0;
            r_lamp1    <= 1'b0;
            r_lamp3    <= 1'b0;
            r_buzz_cnt <= '0;
            r_buzz     <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_ramp[i] <= '0;
            end
        end else if (i_load) begin
            r_mode     <= n_mode;
            r_lamp_cnt <= n_lamp_cnt;
            r_lamp1    <= n_lamp1;
            r_lamp3    <= n_lamp3;
            r_buzz_cnt <= n_buzz_cnt;
            r_buzz     <= n_buzz;
            r_ramp     <= n_ramp;
        end
    end

endmodule

// ===== hw/rtl/sfc_emit.sv =====
// result register: holds one step's bytes and sends them one per request
// depends on sfc_pkg and sample_frame_command_ctl_top_defines.svh
`include "sample_frame_command_ctl_top_defines.svh"
module sfc_emit import sfc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_frame     i_frame,
    input  logic       i_load,
    output logic       o_ready,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_tx_byte,
    output logic       o_byte_valid,
    output logic       o_to_port_one,
    output logic       o_to_port_two,
    output logic       o_last,
    output logic       o_lamp_one,
    output logic       o_lamp_three,
    output logic       o_buzzer,
    output logic [1:0] o_mode
);

    t_frame           r_frame;
    logic             r_full;
    logic [IDX_W-1:0] r_idx;
    logic             take;

    assign take    = r_full && !i_stall;
    assign o_last  = (CNT_W'(r_idx) == r_frame.cnt - CNT_W'(1));
    assign o_ready = !r_full || (take && o_last);

    assign o_valid       = r_full;
    assign o_tx_byte     = r_frame.bytes[r_idx];
    assign o_byte_valid  = r_frame.byte_valid;
    assign o_to_port_one = r_frame.to_port_one;
    assign o_to_port_two = r_frame.to_port_two;
    assign o_lamp_one    = r_frame.lamp_one;
    assign o_lamp_three  = r_frame.lamp_three;
    assign o_buzzer      = r_frame.buzzer;
    assign o_mode        = r_frame.mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_full <= 1'b1;
            r_idx  <= '0;
        end else if (take) begin
            if (o_last) begin
                r_full <= 1'b0;
            end
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_frame <= i_frame;
        end
    end

    `SFC_ASSERT_IMP(a_load_when_free, i_clk, i_rst_n, i_load, o_ready)
    `SFC_ASSERT_IMP(a_idx_in_range, i_clk, i_rst_n, r_full,
        (r_frame.cnt != '0) && (CNT_W'(r_idx) < r_frame.cnt))
    `SFC_ASSERT_NXT(a_mid_frame_holds, i_clk, i_rst_n, take && !o_last, r_full)
    `SFC_ASSERT_NXT(a_load_restarts, i_clk, i_rst_n, i_load, r_full && (r_idx == '0))

endmodule

// ===== hw/rtl/sample_frame_command_ctl_top.sv =====
// top level of the sample frame command controller: channels, registers, stages
// depends on sfc_pkg, sfc_core and sfc_emit
//
// usage
//   input channel: i_valid / o_stall with i_command, i_rx_port, i_rx_byte and
//   four 12-bit samples; a request is taken when i_valid is high, o_stall low.
//   a tick request (command 0) yields ten frame bytes in live or test mode, or
//   one status result when stopped; a byte request yields one reply or status.
//   output channel: o_valid / i_stall, one result byte per request, o_last on
//   the final result of each input request.
//   config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index
//   selects the register, i_cfg_data carries the value (low bits used).
// timing
//   a request waits in the input register until the result register is empty
//   or sends its final byte, then its whole step is computed combinationally
//   into the result register, which sends one byte a cycle while i_stall is
//   low; the next request is taken into the input register meanwhile and
//   moves on as the last byte leaves.
// reset and stall
//   synchronous active-low reset: stopped mode, counters, lamps, buzzer and
//   ramps cleared, registers at their defaults, both stages empty.
//   when the receiver stalls, the current result holds; o_stall rises only once
//   the input register is also full.
module sample_frame_command_ctl_top import sfc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input requests
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_command,
    input  logic                i_rx_port,
    input  logic [7:0]          i_rx_byte,
    input  logic [SAMPLE_W-1:0] i_sample_a,
    input  logic [SAMPLE_W-1:0] i_sample_b,
    input  logic [SAMPLE_W-1:0] i_sample_c,
    input  logic [SAMPLE_W-1:0] i_sample_d,
    // results
    output logic                o_valid,
    input  logic                i_stall,
    output logic [7:0]          o_tx_byte,
    output logic                o_byte_valid,
    output logic                o_to_port_one,
    output logic                o_to_port_two,
    output logic                o_last,
    output logic                o_lamp_one,
    output logic                o_lamp_three,
    output logic                o_buzzer,
    output logic [1:0]          o_mode,
    // register writes
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    // configuration registers
    t_cfg   r_cfg;

    // input register
    t_item  r_item;
    logic   r_in_full;

    logic   emit_ready;
    logic   core_load;
    logic   in_take;
    t_frame frame;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.live_period <= 10'd500;
            r_cfg.test_period <= 10'd250;
            r_cfg.buzz_len    <= 8'd200;
            r_cfg.ramp_limit  <= 12'd1024;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_LIVE_PERIOD: r_cfg.live_period <= i_cfg_data[9:0];
                REG_TEST_PERIOD: r_cfg.test_period <= i_cfg_data[9:0];
                REG_BUZZ_LEN:    r_cfg.buzz_len    <= i_cfg_data[7:0];
                REG_RAMP_LIMIT:  r_cfg.ramp_limit  <= i_cfg_data[SAMPLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // the held request moves into the step logic whenever the result
    // register is empty or sends its final byte in this cycle
    assign core_load = r_in_full && emit_ready;
    assign o_stall   = r_in_full && !emit_ready;
    assign in_take   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_full <= 1'b0;
        end else if (in_take) begin
            r_in_full <= 1'b1;
        end else if (core_load) begin
            r_in_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.command  <= i_command;
            r_item.rx_port  <= i_rx_port;
            r_item.rx_byte  <= i_rx_byte;
            r_item.sample_a <= i_sample_a;
            r_item.sample_b <= i_sample_b;
            r_item.sample_c <= i_sample_c;
            r_item.sample_d <= i_sample_d;
        end
    end

    // step logic: combinational frame assembly, state update registered on load
    sfc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (core_load),
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .o_frame (frame)
    );

    // result register and byte sequencer
    sfc_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame       (frame),
        .i_load        (core_load),
        .o_ready       (emit_ready),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_tx_byte     (o_tx_byte),
        .o_byte_valid  (o_byte_valid),
        .o_to_port_one (o_to_port_one),
        .o_to_port_two (o_to_port_two),
        .o_last        (o_last),
        .o_lamp_one    (o_lamp_one),
        .o_lamp_three  (o_lamp_three),
        .o_buzzer      (o_buzzer),
        .o_mode        (o_mode)
    );

endmodule

// ===== tb/tb_sample_frame_command_ctl_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for sample_frame_command_ctl_top: a directed table, then random
// requests over several register settings, every result byte checked against a predictor
// depends on sfc_pkg and the rtl of the block
module tb_sample_frame_command_ctl_top;
    import sfc_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES      = 6;
    localparam int PHASE_REQS  = 62;

    // one result byte as it leaves the block
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       byte_valid;
        logic       to_port_one;
        logic       to_port_two;
        logic       last;
        logic       lamp_one;
        logic       lamp_three;
        logic       buzzer;
        logic [1:0] mode;
    } t_tx_word;

    // directed table row: the request, and for the obvious rows the typed-in result
    typedef struct {
        t_item    req;
        bit       typed;
        t_tx_word word;
    } t_dir_row;

    // clock, reset and block inputs, all known from time zero
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_valid     = 1'b0;
    logic                i_command   = 1'b0;
    logic                i_rx_port   = 1'b0;
    logic [7:0]          i_rx_byte   = '0;
    logic [SAMPLE_W-1:0] i_sample_a  = '0;
    logic [SAMPLE_W-1:0] i_sample_b  = '0;
    logic [SAMPLE_W-1:0] i_sample_c  = '0;
    logic [SAMPLE_W-1:0] i_sample_d  = '0;
    logic                i_stall     = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic [1:0]          i_cfg_index = '0;
    logic [CFG_W-1:0]    i_cfg_data  = '0;

    logic                o_stall;
    logic                o_valid;
    logic [7:0]          o_tx_byte;
    logic                o_byte_valid;
    logic                o_to_port_one;
    logic                o_to_port_two;
    logic                o_last;
    logic                o_lamp_one;
    logic                o_lamp_three;
    logic                o_buzzer;
    logic [1:0]          o_mode;
    logic                o_cfg_ready;

    // predictor state, mirrors the block
    logic [1:0]  run_mode;
    logic [9:0]  lamp_cnt;
    logic        lamp_one_lvl;
    logic        lamp_three_lvl;
    logic [7:0]  buzz_cnt;
    logic        buzz_lvl;
    logic [11:0] ramp [CHANNELS];

    // predictor copy of the registers
    logic [9:0]  live_period;
    logic [9:0]  test_period;
    logic [7:0]  buzz_len;
    logic [11:0] wrap_limit;

    t_tx_word    expected_tx [$];
    t_dir_row    dir_rows [$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          quiet_left  = 0;

    sample_frame_command_ctl_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_rx_port     (i_rx_port),
        .i_rx_byte     (i_rx_byte),
        .i_sample_a    (i_sample_a),
        .i_sample_b    (i_sample_b),
        .i_sample_c    (i_sample_c),
        .i_sample_d    (i_sample_d),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_tx_byte     (o_tx_byte),
        .o_byte_valid  (o_byte_valid),
        .o_to_port_one (o_to_port_one),
        .o_to_port_two (o_to_port_two),
        .o_last        (o_last),
        .o_lamp_one    (o_lamp_one),
        .o_lamp_three  (o_lamp_three),
        .o_buzzer      (o_buzzer),
        .o_mode        (o_mode),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit, far above the slowest legal run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic log_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            log_error($sformatf("%s got %h want %h", name, got, want));
    endtask

    // work out the result bytes of one accepted request and queue them
    task automatic predict_step(input t_item req);
        logic [7:0]  frame [FRAME_LEN];
        logic [11:0] smp [CHANNELS];
        logic [11:0] vals [CHANNELS];
        logic [7:0]  reply;
        logic        to1;
        logic        to2;
        bit          send;
        int          ch;
        int          sum;
        int          nxt;
        int          n;
        n     = 0;
        reply = '0;
        to1   = 1'b0;
        to2   = 1'b0;
        send  = 1'b0;
        smp[0] = req.sample_a;
        smp[1] = req.sample_b;
        smp[2] = req.sample_c;
        smp[3] = req.sample_d;
        if (!req.command) begin
            if (run_mode == MODE_LIVE || run_mode == MODE_TEST) begin
                for (ch = 0; ch < CHANNELS; ch++) begin
                    if (run_mode == MODE_LIVE) begin
                        vals[ch] = smp[ch];
                    end else begin
                        // ramps grow by 2, 4, 6, 8 and wrap once past the limit
                        sum = int'(ramp[ch]) + 2 * (ch + 1);
                        ramp[ch] = (sum > int'(wrap_limit)) ? 12'd0 : 12'(sum);
                        vals[ch] = ramp[ch];
                    end
                end
                frame[0] = FRAME_SOF;
                for (ch = 0; ch < CHANNELS; ch++) begin
                    frame[2 * ch + 1] = 8'(vals[ch] >> 7);
                    frame[2 * ch + 2] = {1'b0, vals[ch][6:0]};
                end
                frame[FRAME_LEN - 1] = FRAME_EOF;
                // lamp counter, compared before it is stored
                nxt = int'(lamp_cnt) + 1;
                if (nxt > int'((run_mode == MODE_LIVE) ? live_period : test_period)) begin
                    lamp_one_lvl = ~lamp_one_lvl;
                    lamp_cnt     = '0;
                end else begin
                    lamp_cnt = 10'(nxt);
                end
                n = FRAME_LEN;
            end else begin
                lamp_one_lvl = 1'b0;
            end
            // buzzer runs after the mode action
            if (buzz_cnt != 0) begin
                nxt      = int'(buzz_cnt) + 1;
                buzz_lvl = 1'b1;
                buzz_cnt = (nxt > int'(buzz_len)) ? 8'd0 : 8'(nxt);
            end else begin
                buzz_lvl = 1'b0;
            end
            for (ch = 0; ch < n; ch++)
                expected_tx.push_back('{frame[ch], 1'b1, 1'b1, 1'b1, (ch == n - 1),
                                        lamp_one_lvl, lamp_three_lvl, buzz_lvl, run_mode});
        end else begin
            case (req.rx_byte)
                CMD_LIVE: begin
                    run_mode = MODE_LIVE;
                    reply    = ACK_LIVE;
                    to1      = ~req.rx_port;
                    to2      = req.rx_port;
                    send     = 1'b1;
                end
                CMD_STOP: begin
                    run_mode = MODE_STOP;
                    reply    = ACK_STOP;
                    to1      = ~req.rx_port;
                    to2      = req.rx_port;
                    send     = 1'b1;
                end
                CMD_TEST: begin
                    // test ack always leaves on port one
                    run_mode = MODE_TEST;
                    reply    = ACK_TEST;
                    to1      = 1'b1;
                    to2      = 1'b0;
                    send     = 1'b1;
                end
                default: ;
            endcase
            if (send)
                buzz_cnt = 8'd1;
            // any byte on port two toggles lamp three
            if (req.rx_port)
                lamp_three_lvl = ~lamp_three_lvl;
            if (send) begin
                expected_tx.push_back('{reply, 1'b1, to1, to2, 1'b1,
                                        lamp_one_lvl, lamp_three_lvl, buzz_lvl, run_mode});
                n = 1;
            end
        end
        // nothing sent: a single status result
        if (n == 0)
            expected_tx.push_back('{8'h00, 1'b0, 1'b0, 1'b0, 1'b1,
                                    lamp_one_lvl, lamp_three_lvl, buzz_lvl, run_mode});
    endtask

    function automatic t_item tick_req(input logic [11:0] a, input logic [11:0] b,
                                       input logic [11:0] c, input logic [11:0] d);
        return '{1'b0, 1'b0, 8'h00, a, b, c, d};
    endfunction

    function automatic t_item byte_req(input logic port, input logic [7:0] data);
        return '{1'b1, port, data, 12'h000, 12'h000, 12'h000, 12'h000};
    endfunction

    function automatic t_tx_word status_word(input logic l1, input logic l3,
                                             input logic bz, input logic [1:0] md);
        return '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, l1, l3, bz, md};
    endfunction

    // mostly full-range samples, now and then the two extremes
    function automatic logic [11:0] rand_sample();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 12'h000;
        if (r == 1)
            return 12'hfff;
        return 12'($urandom_range(0, 4095));
    endfunction

    // ticks most of the time, the three commands, and some stray bytes
    function automatic t_item random_request();
        t_item req;
        int    pick;
        int    c;
        pick         = $urandom_range(0, 99);
        req.command  = (pick >= 60);
        req.rx_port  = 1'($urandom_range(0, 1));
        req.rx_byte  = 8'($urandom_range(0, 255));
        req.sample_a = rand_sample();
        req.sample_b = rand_sample();
        req.sample_c = rand_sample();
        req.sample_d = rand_sample();
        if (pick >= 60 && pick < 80) begin
            // live and test favored so that frames keep coming
            c = $urandom_range(0, 19);
            req.rx_byte = (c < 9) ? CMD_LIVE : (c < 17) ? CMD_TEST : CMD_STOP;
        end
        return req;
    endfunction

    // sender gap: mostly none or short, a few long, with runs of back-to-back requests
    function automatic int pick_gap();
        int r;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            quiet_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // drive one request from a falling edge, hold it until taken
    task automatic send_request(input t_item req, input bit typed, input t_tx_word word);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_command  <= req.command;
        i_rx_port  <= req.rx_port;
        i_rx_byte  <= req.rx_byte;
        i_sample_a <= req.sample_a;
        i_sample_b <= req.sample_b;
        i_sample_c <= req.sample_c;
        i_sample_d <= req.sample_d;
        i_valid    <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        predict_step(req);
        // typed rows are single-result rows: the typed word replaces the predicted one
        if (typed) begin
            void'(expected_tx.pop_back());
            expected_tx.push_back(word);
        end
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_LIVE_PERIOD: live_period = data[9:0];
            REG_TEST_PERIOD: test_period = data[9:0];
            REG_BUZZ_LEN:    buzz_len    = data[7:0];
            REG_RAMP_LIMIT:  wrap_limit  = data[11:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // hold off until every expected byte is out, then let the pipe settle
    task automatic wait_drained(input int settle);
        while (expected_tx.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // receiver stall: short free runs and stalls, some long ones, some long free stretches
    initial begin : stall_gen
        int r;
        int hold;
        forever begin
            r    = $urandom_range(0, 99);
            hold = (r < 8) ? $urandom_range(60, 200) : $urandom_range(1, 6);
            @(negedge i_clk);
            i_stall <= 1'b0;
            repeat (hold - 1) @(negedge i_clk);
            r    = $urandom_range(0, 99);
            hold = (r < 70) ? $urandom_range(1, 2) :
                   (r < 94) ? $urandom_range(3, 8) : $urandom_range(15, 30);
            @(negedge i_clk);
            i_stall <= 1'b1;
            repeat (hold - 1) @(negedge i_clk);
        end
    end

    // result checker: every taken byte against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_tx_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_tx.size() == 0) begin
                log_error($sformatf("result %h with nothing expected", o_tx_byte));
            end else begin
                want = expected_tx.pop_front();
                check_field("tx_byte", o_tx_byte, want.tx_byte);
                check_field("byte_valid", 8'(o_byte_valid), 8'(want.byte_valid));
                check_field("to_port_one", 8'(o_to_port_one), 8'(want.to_port_one));
                check_field("to_port_two", 8'(o_to_port_two), 8'(want.to_port_two));
                check_field("last", 8'(o_last), 8'(want.last));
                check_field("lamp_one", 8'(o_lamp_one), 8'(want.lamp_one));
                check_field("lamp_three", 8'(o_lamp_three), 8'(want.lamp_three));
                check_field("buzzer", 8'(o_buzzer), 8'(want.buzzer));
                check_field("mode", 8'(o_mode), 8'(want.mode));
            end
        end
    end

    initial begin : main_seq
        logic [CFG_W-1:0] cfg_v [4];
        int               ph;
        int               k;

        // predictor after reset
        run_mode       = MODE_STOP;
        lamp_cnt       = '0;
        lamp_one_lvl   = 1'b0;
        lamp_three_lvl = 1'b0;
        buzz_cnt       = '0;
        buzz_lvl       = 1'b0;
        for (k = 0; k < CHANNELS; k++)
            ramp[k] = '0;
        live_period = 10'd500;
        test_period = 10'd250;
        buzz_len    = 8'd200;
        wrap_limit  = 12'd1024;

        // directed table, register defaults
        // stopped tick right after reset: bare status
        dir_rows.push_back('{tick_req(12'h000, 12'h000, 12'h000, 12'h000), 1'b1,
                             status_word(1'b0, 1'b0, 1'b0, MODE_STOP)});
        // non-command bytes on port one and port two, the second toggles lamp three
        dir_rows.push_back('{byte_req(1'b0, 8'h00), 1'b1,
                             status_word(1'b0, 1'b0, 1'b0, MODE_STOP)});
        dir_rows.push_back('{byte_req(1'b1, 8'hff), 1'b1,
                             status_word(1'b0, 1'b1, 1'b0, MODE_STOP)});
        // live command on port one: ack back on port one
        dir_rows.push_back('{byte_req(1'b0, CMD_LIVE), 1'b1,
                             '{ACK_LIVE, 1'b1, 1'b1, 1'b0, 1'b1,
                               1'b0, 1'b1, 1'b0, MODE_LIVE}});
        // live frames: sample extremes and the split at 128
        dir_rows.push_back('{tick_req(12'hfff, 12'hfff, 12'hfff, 12'hfff), 1'b0, '0});
        dir_rows.push_back('{tick_req(12'h000, 12'h000, 12'h000, 12'h000), 1'b0, '0});
        dir_rows.push_back('{tick_req(12'h080, 12'h07f, 12'h800, 12'h555), 1'b0, '0});
        dir_rows.push_back('{tick_req(12'haaa, 12'h555, 12'h001, 12'hf80), 1'b0, '0});
        // test command from port two, ack still goes to port one
        dir_rows.push_back('{byte_req(1'b1, CMD_TEST), 1'b0, '0});
        dir_rows.push_back('{tick_req(12'hfff, 12'h000, 12'hfff, 12'h000), 1'b0, '0});
        dir_rows.push_back('{tick_req(12'h123, 12'h456, 12'h789, 12'habc), 1'b0, '0});
        dir_rows.push_back('{tick_req(12'h000, 12'hfff, 12'h000, 12'hfff), 1'b0, '0});
        // bytes next to the command codes do nothing but lamp three
        dir_rows.push_back('{byte_req(1'b0, 8'ha4), 1'b0, '0});
        dir_rows.push_back('{byte_req(1'b1, 8'ha8), 1'b0, '0});
        // stop from port two, then a stopped tick clears lamp one
        dir_rows.push_back('{byte_req(1'b1, CMD_STOP), 1'b0, '0});
        dir_rows.push_back('{tick_req(12'h7ff, 12'h800, 12'h07f, 12'h080), 1'b0, '0});
        dir_rows.push_back('{byte_req(1'b1, CMD_LIVE), 1'b0, '0});
        dir_rows.push_back('{tick_req(12'h001, 12'h002, 12'h003, 12'h004), 1'b0, '0});
        dir_rows.push_back('{byte_req(1'b0, CMD_STOP), 1'b0, '0});
        dir_rows.push_back('{byte_req(1'b0, CMD_TEST), 1'b0, '0});
        dir_rows.push_back('{tick_req(12'hfff, 12'hfff, 12'hfff, 12'hfff), 1'b0, '0});
        dir_rows.push_back('{byte_req(1'b1, 8'h7f), 1'b0, '0});
        dir_rows.push_back('{byte_req(1'b0, CMD_STOP), 1'b0, '0});
        dir_rows.push_back('{tick_req(12'h000, 12'h000, 12'h000, 12'h000), 1'b0, '0});

        // reset held from time zero, released on a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k])
            send_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].word);
        i_valid <= 1'b0;
        // sender waits for every expected byte before moving on
        wait_drained(4);

        // random phases, registers rewritten while idle
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    // value one: lamp flips every other tick, ramps wrap at once
                    cfg_v[0] = 12'd1;
                    cfg_v[1] = 12'd1;
                    cfg_v[2] = 12'd1;
                    cfg_v[3] = 12'd1;
                end
                1: begin
                    // all ones, registers keep only their low bits
                    cfg_v[0] = 12'hfff;
                    cfg_v[1] = 12'hfff;
                    cfg_v[2] = 12'hfff;
                    cfg_v[3] = 12'hfff;
                end
                2: begin
                    cfg_v[0] = 12'($urandom_range(1, 1023));
                    cfg_v[1] = 12'($urandom_range(1, 1023));
                    cfg_v[2] = 12'($urandom_range(1, 255));
                    cfg_v[3] = 12'($urandom_range(1, 4095));
                end
                3: begin
                    // short periods so lamps, buzzer and ramps all turn over
                    cfg_v[0] = 12'($urandom_range(1, 6));
                    cfg_v[1] = 12'($urandom_range(1, 6));
                    cfg_v[2] = 12'($urandom_range(1, 8));
                    cfg_v[3] = 12'($urandom_range(8, 60));
                end
                4: begin
                    // zero values: every event fires on every tick
                    cfg_v[0] = 12'd0;
                    cfg_v[1] = 12'd0;
                    cfg_v[2] = 12'd0;
                    cfg_v[3] = 12'd0;
                end
                default: begin
                    cfg_v[0] = 12'd500;
                    cfg_v[1] = 12'd250;
                    cfg_v[2] = 12'd200;
                    cfg_v[3] = 12'd1024;
                end
            endcase
            write_reg(REG_LIVE_PERIOD, cfg_v[0]);
            write_reg(REG_TEST_PERIOD, cfg_v[1]);
            write_reg(REG_BUZZ_LEN, cfg_v[2]);
            write_reg(REG_RAMP_LIMIT, cfg_v[3]);
            for (k = 0; k < PHASE_REQS; k++)
                send_request(random_request(), 1'b0, '0);
            i_valid <= 1'b0;
            wait_drained(4);
        end

        // tail: room for any stray result to show up
        wait_drained(20);
        if (error_count == 0 && expected_tx.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
